// File: rtl/core/lmps_pkg.sv
`timescale 1ns / 1ps

package lmps_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_ROTATION   = 2'd1,
    CFG_SERPENTINE = 2'd2
  } cfg_reg_e;

  // Quarter-turn codes
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  localparam logic [7:0] BRIGHTNESS_RESET = 8'd16;

  typedef struct packed {
    logic [7:0] bright_ceil;
    rot_e       rotation;
    logic       serpentine;
  } cfg_t;

  // One pixel as held in the input stage
  typedef struct packed {
    logic [3:0] column;
    logic [3:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One mapped and scaled result
  typedef struct packed {
    logic [7:0] led_index;
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
  } result_t;

endpackage

// File: rtl/core/led_matrix_pixel_map_scale.sv
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// pixel    in_valid_i / in_stall_o   column_i row_i red_in_i green_in_i blue_in_i
// result   out_valid_o / out_stall_i led_index_o red_out_o green_out_o blue_out_o
// config   cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// One pixel per cycle unless in_stall_o is raised: input register, then result
// register, with the mapping and the three 8x8 scaling multiplies between.
// Reset clears the valid flags and loads brightness 16, rotation 0,
// serpentine off. out_stall_i freezes the result register; the input
// register keeps taking a pixel until both stages hold one.
module led_matrix_pixel_map_scale
  import lmps_pkg::*;
#(
  parameter int unsigned MATRIX_WIDTH   = 16,
  parameter int unsigned MATRIX_HEIGHT  = 16,
  parameter int unsigned BRIGHTNESS_CAP = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] column_i,
  input  logic [3:0] row_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] led_index_o,
  output logic [4:0] red_out_o,
  output logic [4:0] green_out_o,
  output logic [4:0] blue_out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [7:0] Cap = 8'(BRIGHTNESS_CAP);

  cfg_t       cfg;
  logic [7:0] limit;

  logic    in_valid_q, in_valid_d;
  pixel_t  pix_q;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic out_adv, in_adv, in_accept;

  assign cfg_ready_o = 1'b1;

  lmps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register takes a new value when empty or being drained
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign limit = (cfg.bright_ceil > Cap) ? Cap : cfg.bright_ceil;

  lmps_map #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_map (
    .column_i     (pix_q.column),
    .row_i        (pix_q.row),
    .rotation_i   (cfg.rotation),
    .serpentine_i (cfg.serpentine),
    .led_index_o  (res_d.led_index)
  );

  lmps_scale u_scale_red (
    .value_i  (pix_q.red),
    .limit_i  (limit),
    .scaled_o (res_d.red)
  );

  lmps_scale u_scale_green (
    .value_i  (pix_q.green),
    .limit_i  (limit),
    .scaled_o (res_d.green)
  );

  lmps_scale u_scale_blue (
    .value_i  (pix_q.blue),
    .limit_i  (limit),
    .scaled_o (res_d.blue)
  );

  assign in_valid_d  = in_adv ? in_valid_i : in_valid_q;
  assign out_valid_d = out_adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q <= '{column: column_i, row: row_i, red: red_in_i,
                 green: green_in_i, blue: blue_in_i};
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = res_q.led_index;
  assign red_out_o   = res_q.red;
  assign green_out_o = res_q.green;
  assign blue_out_o  = res_q.blue;

  // An accepted pixel occupies the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted pixel not held in input register");

  // A result only appears after a pixel sat in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result without a pixel");

  // Both stages full and output stalled: no new pixel may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input register overwritten while full");

  // An empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("stall raised with empty result register");

  // A full input stage drains when the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("pixel lost between stages");

endmodule

// File: rtl/core/lmps_cfg.sv
`timescale 1ns / 1ps

module lmps_cfg
  import lmps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BRIGHTNESS: cfg_d.bright_ceil = cfg_data_i;
        CFG_ROTATION:   cfg_d.rotation = rot_e'(cfg_data_i[1:0]);
        CFG_SERPENTINE: cfg_d.serpentine = cfg_data_i[0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_ceil <= BRIGHTNESS_RESET;
      cfg_q.rotation    <= ROT_0;
      cfg_q.serpentine  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/lmps_map.sv
`timescale 1ns / 1ps

module lmps_map
  import lmps_pkg::*;
#(
  parameter int unsigned MATRIX_WIDTH  = 16,
  parameter int unsigned MATRIX_HEIGHT = 16
) (
  input  logic [3:0] column_i,
  input  logic [3:0] row_i,
  input  rot_e       rotation_i,
  input  logic       serpentine_i,
  output logic [7:0] led_index_o
);

  // Coordinates wrap modulo 256; a width of 256 folds to zero, which keeps
  // the product correct mod 256.
  localparam logic [7:0] WidthM1  = 8'(MATRIX_WIDTH - 1);
  localparam logic [7:0] HeightM1 = 8'(MATRIX_HEIGHT - 1);
  localparam logic [7:0] Width8   = 8'(MATRIX_WIDTH);

  logic [7:0]  x, y, rot_x, rot_y, phys_x;
  logic [15:0] row_base;

  assign x = {4'b0, column_i};
  assign y = {4'b0, row_i};

  always_comb begin
    unique case (rotation_i)
      ROT_0: begin
        rot_x = x;
        rot_y = y;
      end
      ROT_90: begin
        rot_x = HeightM1 - y;
        rot_y = x;
      end
      ROT_180: begin
        rot_x = WidthM1 - x;
        rot_y = HeightM1 - y;
      end
      ROT_270: begin
        rot_x = y;
        rot_y = WidthM1 - x;
      end
      default: begin
        rot_x = x;
        rot_y = y;
      end
    endcase
  end

  // Reverse the column order on odd physical rows
  assign phys_x   = (serpentine_i && rot_y[0]) ? (WidthM1 - rot_x) : rot_x;
  assign row_base = rot_y * Width8;

  assign led_index_o = row_base[7:0] + phys_x;

endmodule

// File: rtl/core/lmps_scale.sv
`timescale 1ns / 1ps

module lmps_scale (
  input  logic [7:0] value_i,
  input  logic [7:0] limit_i,
  output logic [4:0] scaled_o
);

  logic [15:0] prod;
  logic [16:0] sum;

  assign prod = value_i * limit_i;

  // floor(p / 255) for any product p of two 8-bit values: (p + (p >> 8) + 1) >> 8
  assign sum = {1'b0, prod} + {9'b0, prod[15:8]} + 17'd1;

  assign scaled_o = sum[12:8];

endmodule

// File: sim/tb_led_matrix_pixel_map_scale.sv
`timescale 1ns / 1ps

module tb_led_matrix_pixel_map_scale;
  import lmps_pkg::*;

  localparam int MATRIX_W    = 16;
  localparam int MATRIX_H    = 16;
  localparam int BRIGHT_CAP  = 16;
  localparam int PHASE_ITEMS = 75;
  localparam int LONG_HOLD   = 60;
  localparam int PIPE_PAD    = 4;
  localparam int IDLE_LIMIT  = 4000;

  localparam logic [7:0] W_M1 = 8'(MATRIX_W - 1);
  localparam logic [7:0] H_M1 = 8'(MATRIX_H - 1);
  localparam logic [1:0] CFG_NONE = 2'd3;  // no register behind this index

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [3:0] column_i    = '0;
  logic [3:0] row_i       = '0;
  logic [7:0] red_in_i    = '0;
  logic [7:0] green_in_i  = '0;
  logic [7:0] blue_in_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] led_index_o;
  logic [4:0] red_out_o;
  logic [4:0] green_out_o;
  logic [4:0] blue_out_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;

  led_matrix_pixel_map_scale #(
    .MATRIX_WIDTH   (MATRIX_W),
    .MATRIX_HEIGHT  (MATRIX_H),
    .BRIGHTNESS_CAP (BRIGHT_CAP)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_index_o (led_index_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the block's registers, loaded with the reset values
  logic [7:0] bright_sh = BRIGHTNESS_RESET;
  rot_e       rot_sh    = ROT_0;
  logic       serp_sh   = 1'b0;

  pixel_t  pixel_q[$];
  result_t led_expect_q[$];
  result_t led_got;
  result_t led_exp;

  logic in_acc = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_req  = 0;
  int   hold_ack  = 0;
  int   hold_left = 0;
  int   fail_cnt  = 0;
  int   idle_cyc  = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [4:0] scale_chan(input logic [7:0] val, input logic [7:0] lim);
    logic [15:0] prod;
    prod = val * lim;
    prod = prod / 16'd255;
    return prod[4:0];
  endfunction

  function automatic result_t predict_led(input pixel_t px);
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  lim;
    logic [15:0] pos;
    result_t     res;
    rx = {4'd0, px.column};
    ry = {4'd0, px.row};
    case (rot_sh)
      ROT_90: begin
        rx = H_M1 - {4'd0, px.row};
        ry = {4'd0, px.column};
      end
      ROT_180: begin
        rx = W_M1 - {4'd0, px.column};
        ry = H_M1 - {4'd0, px.row};
      end
      ROT_270: begin
        rx = {4'd0, px.row};
        ry = W_M1 - {4'd0, px.column};
      end
      default: ;
    endcase
    // odd physical rows run backwards
    if (serp_sh && ry[0]) begin
      rx = W_M1 - rx;
    end
    lim = (bright_sh > 8'(BRIGHT_CAP)) ? 8'(BRIGHT_CAP) : bright_sh;
    pos = ry * 16'(MATRIX_W) + rx;
    res.led_index = pos[7:0];
    res.red       = scale_chan(px.red, lim);
    res.green     = scale_chan(px.green, lim);
    res.blue      = scale_chan(px.blue, lim);
    return res;
  endfunction

  // Pixel driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {column_i, row_i, red_in_i, green_in_i, blue_in_i} <= pixel_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Predict on each accepted request, check each delivered result
  always @(posedge clk_i) begin
    in_acc <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      led_expect_q.push_back(
        predict_led({column_i, row_i, red_in_i, green_in_i, blue_in_i}));
    end
    if (out_valid_o && !out_stall_i) begin
      led_got = {led_index_o, red_out_o, green_out_o, blue_out_o};
      if (led_expect_q.size() == 0) begin
        fail_cnt <= fail_cnt + 1;
        if (fail_cnt < 10) begin
          $display("ERROR: unexpected result idx=%0d r=%0d g=%0d b=%0d",
                   led_got.led_index, led_got.red, led_got.green, led_got.blue);
        end
      end else begin
        led_exp = led_expect_q.pop_front();
        if (led_got !== led_exp) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10) begin
            $display({"ERROR: idx exp %0d got %0d, r exp %0d got %0d, ",
                      "g exp %0d got %0d, b exp %0d got %0d"},
                     led_exp.led_index, led_got.led_index, led_exp.red, led_got.red,
                     led_exp.green, led_got.green, led_exp.blue, led_got.blue);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BRIGHTNESS: bright_sh = data;
      CFG_ROTATION:   rot_sh    = rot_e'(data[1:0]);
      CFG_SERPENTINE: serp_sh   = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_mapping(input logic [7:0] bright, input rot_e rot, input logic serp);
    // upper data bits are don't-care on the narrow registers; randomize them
    write_reg(CFG_BRIGHTNESS, bright);
    write_reg(CFG_ROTATION, {6'($urandom_range(63)), rot});
    write_reg(CFG_SERPENTINE, {7'($urandom_range(127)), serp});
  endtask

  // Hold until every request is taken and every result has come back;
  // check at the rising edge, where the driver's queue and valid are settled
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || led_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_PAD) @(posedge clk_i);
  endtask

  task automatic add_pixel(input logic [3:0] col, input logic [3:0] row,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t px;
    px.column = col;
    px.row    = row;
    px.red    = r;
    px.green  = g;
    px.blue   = b;
    pixel_q.push_back(px);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'(254 + $urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] bright;
    rot_e       rot;
    logic       serp;
    logic [7:0] dir_bright[8];
    dir_bright = '{8'd16, 8'd0, 8'd255, 8'd1, 8'd17, 8'd15, 8'd16, 8'd255};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: every quarter turn with and without serpentine, reset setting first
    for (int d = 0; d < 8; d++) begin
      if (d != 0) begin
        set_mapping(dir_bright[d], rot_e'(d % 4), 1'(d / 4));
      end
      add_pixel(4'd0, 4'd0, 8'd255, 8'd0, 8'd128);
      add_pixel(4'd15, 4'd15, 8'd0, 8'd255, 8'd1);
      add_pixel(4'(2 * d + 1), 4'(14 - 2 * d), 8'd254, 8'd127, 8'd64);
      wait_drained();
    end
    // a write to the unused index must leave the mapping alone
    write_reg(CFG_NONE, 8'hA5);
    add_pixel(4'd3, 4'd5, 8'd200, 8'd100, 8'd50);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       bright = 8'd255;
        1:       bright = 8'd0;
        2:       bright = 8'd16;
        3:       bright = 8'd17;
        4:       bright = 8'd1;
        5:       bright = 8'd31;
        6:       bright = 8'd8;
        7:       bright = 8'd255;
        default: bright = 8'($urandom_range(255));
      endcase
      if (p < 8) begin
        rot  = rot_e'(p % 4);
        serp = 1'(p / 4);
      end else begin
        rot  = rot_e'($urandom_range(3));
        serp = 1'($urandom_range(1));
      end
      set_mapping(bright, rot, serp);
      @(posedge clk_i);
      case (p / 4)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // back up the pipe while pixels keep coming
      if (p == 1 || p == 9) begin
        hold_req = hold_req + 1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        add_pixel(4'($urandom_range(15)), 4'($urandom_range(15)),
                  rand_chan(), rand_chan(), rand_chan());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && led_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lmps_pkg.sv
rtl/core/lmps_cfg.sv
rtl/core/lmps_map.sv
rtl/core/lmps_scale.sv
rtl/core/led_matrix_pixel_map_scale.sv
sim/tb_led_matrix_pixel_map_scale.sv
